/* src/tvg_pkg.sv */
// ----------------------------------------------------------------------------
// Torus vertex generator package
// Shared widths, fixed-point constants, register indexes and the arctangent
// table generator used by the CORDIC lanes.
// ----------------------------------------------------------------------------
package tvg_pkg;

    localparam int IDX_W     = 10;  // grid index width
    localparam int SEG_W     = 11;  // segment count width
    localparam int RAD_W     = 16;  // radius register width
    localparam int CFG_W     = 16;  // configuration data width
    localparam int TEX_W     = 16;  // texture coordinate width
    localparam int TRIG_W    = 32;  // Q30 sine and cosine
    localparam int HP_W      = 33;  // half pi in Q32
    localparam int DIV_STEPS = HP_W;
    localparam int NUM_W     = HP_W + SEG_W;
    localparam int XY_W      = 33;  // CORDIC x and y
    localparam int Z_W       = 36;  // CORDIC angle accumulator
    localparam int POSXY_W   = 18;
    localparam int POSZ_W    = 17;
    localparam int NORM_W    = 16;
    localparam int VIDX_W    = 20;
    localparam int IN_W      = 24;
    localparam int OUT_W     = 216;

    localparam int MAX_SEGMENTS_DEF  = 1024;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic [HP_W-1:0] HALF_PI_Q32 = HP_W'((PI_Q60 + 64'd268435456) >> 29);
    localparam logic signed [XY_W-1:0] GAIN_Q30 = 33'sd652032874;
    localparam logic signed [TRIG_W-1:0] ONE_Q30 = 32'sd1073741824;

    localparam logic [RAD_W-1:0] RING_RADIUS_RST = 16'd4096;
    localparam logic [RAD_W-1:0] TUBE_RADIUS_RST = 16'd1024;
    localparam logic [SEG_W-1:0] RING_SEGS_RST   = 11'd32;
    localparam logic [SEG_W-1:0] TUBE_SEGS_RST   = 11'd16;

    typedef enum logic [1:0] {
        CFG_RING_RADIUS   = 2'd0,
        CFG_TUBE_RADIUS   = 2'd1,
        CFG_RING_SEGMENTS = 2'd2,
        CFG_TUBE_SEGMENTS = 2'd3
    } cfg_idx_t;

    // Results of one angle lane.
    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_v;
        logic signed [TRIG_W-1:0] sin_v;
        logic [IDX_W-1:0]         idx;
        logic [IDX_W-1:0]         nxt;
        logic [TEX_W-1:0]         tex;
    } lane_out_t;

    // atan(2^-k) in Q32, rounded, from the odd power series in Q60.
    function automatic logic signed [Z_W-1:0] atan_q32(input int k);
        logic signed [63:0] sum;
        logic [63:0]        term;
        int                 n;
        int                 sh;
        sum = 64'sd0;
        if (k == 0) begin
            sum = $signed(PI_Q60 >> 2);
        end else begin
            for (n = 0; k * (2 * n + 1) < 61; n++) begin
                sh   = k * (2 * n + 1);
                term = (64'd1 << 60) >> sh;
                term = term / 64'(2 * n + 1);
                if (n % 2 == 1) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
        end
        return Z_W'((sum + (64'sd1 <<< 27)) >>> 28);
    endfunction

endpackage

/* src/tvg_lane.sv */
// ----------------------------------------------------------------------------
// Torus angle lane
// Reduces a grid index modulo its segment count, splits the turn into a
// quadrant and a residual angle by long division, and runs a CORDIC to get
// Q30 cosine and sine. Also produces the wrapped next index and the Q0.16
// texture coordinate. Fully pipelined, one step per register stage.
// ----------------------------------------------------------------------------
module tvg_lane import tvg_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [IDX_W-1:0] k_in,
    input  logic [SEG_W-1:0] seg,
    output lane_out_t        res
);

    typedef struct packed {
        logic [1:0]       q;
        logic             rz;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] nx;
    } side_t;

    // Modulo stages.
    logic [SEG_W-1:0] mrem_reg [IDX_W];
    logic [SEG_W-1:0] mrem_next[IDX_W];
    logic [IDX_W-1:0] mk_reg   [IDX_W];
    logic [IDX_W-1:0] mk_next  [IDX_W];

    // Quadrant and product stages.
    logic [1:0]       q_reg, q_next;
    logic [SEG_W-1:0] r_reg, r_next;
    logic [IDX_W-1:0] qi_reg, qi_next;
    logic [IDX_W-1:0] qn_reg, qn_next;
    logic [NUM_W-1:0] num_reg, num_next;
    side_t            ps_reg, ps_next;

    // Divider stages: residual angle and texture coordinate.
    logic [SEG_W-1:0] drem_reg [DIV_STEPS];
    logic [SEG_W-1:0] drem_next[DIV_STEPS];
    logic [HP_W-1:0]  dacc_reg [DIV_STEPS];
    logic [HP_W-1:0]  dacc_next[DIV_STEPS];
    logic [SEG_W-1:0] trem_reg [DIV_STEPS];
    logic [SEG_W-1:0] trem_next[DIV_STEPS];
    logic [TEX_W-1:0] tq_reg   [DIV_STEPS];
    logic [TEX_W-1:0] tq_next  [DIV_STEPS];
    side_t            ds_reg   [DIV_STEPS];
    side_t            ds_next  [DIV_STEPS];

    // CORDIC stages.
    logic signed [XY_W-1:0] cx_reg [CORDIC_STAGES];
    logic signed [XY_W-1:0] cx_next[CORDIC_STAGES];
    logic signed [XY_W-1:0] cy_reg [CORDIC_STAGES];
    logic signed [XY_W-1:0] cy_next[CORDIC_STAGES];
    logic signed [Z_W-1:0]  cz_reg [CORDIC_STAGES];
    logic signed [Z_W-1:0]  cz_next[CORDIC_STAGES];
    side_t                  cs_reg [CORDIC_STAGES];
    side_t                  cs_next[CORDIC_STAGES];
    logic [TEX_W-1:0]       ct_reg [CORDIC_STAGES];
    logic [TEX_W-1:0]       ct_next[CORDIC_STAGES];
    logic signed [Z_W-1:0]  atan_w [CORDIC_STAGES];

    lane_out_t res_reg, res_next;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_atan
        localparam logic signed [Z_W-1:0] ATAN = atan_q32(g);
        assign atan_w[g] = ATAN;
    end

    // Restoring remainder, one dividend bit per stage.
    always_comb begin : c_mod
        logic [SEG_W:0]   trial;
        logic [SEG_W-1:0] prem;
        logic [IDX_W-1:0] pk;
        for (int t = 0; t < IDX_W; t++) begin
            if (t == 0) begin
                prem = '0;
                pk   = k_in;
            end else begin
                prem = mrem_reg[t-1];
                pk   = mk_reg[t-1];
            end
            trial = {prem, pk[IDX_W-1]};
            if (trial >= {1'b0, seg}) begin
                mrem_next[t] = SEG_W'(trial - {1'b0, seg});
            end else begin
                mrem_next[t] = trial[SEG_W-1:0];
            end
            mk_next[t] = {pk[IDX_W-2:0], 1'b0};
        end
    end

    // Quadrant split of 4*i against the segment count.
    always_comb begin : c_quad
        logic [IDX_W-1:0] im;
        logic [SEG_W+1:0] k4;
        logic [SEG_W+1:0] s1;
        logic [SEG_W+1:0] s2;
        logic [SEG_W+1:0] s3;
        logic [SEG_W+1:0] sub;
        logic [SEG_W-1:0] inc;
        im = IDX_W'(mrem_reg[IDX_W-1]);
        k4 = {1'b0, im, 2'b00};
        s1 = {2'b00, seg};
        s2 = {1'b0, seg, 1'b0};
        s3 = s1 + s2;
        if (k4 >= s3) begin
            q_next = 2'd3;
            sub    = s3;
        end else if (k4 >= s2) begin
            q_next = 2'd2;
            sub    = s2;
        end else if (k4 >= s1) begin
            q_next = 2'd1;
            sub    = s1;
        end else begin
            q_next = 2'd0;
            sub    = '0;
        end
        r_next  = SEG_W'(k4 - sub);
        qi_next = im;
        inc     = {1'b0, im} + SEG_W'(1);
        qn_next = (inc == seg) ? '0 : IDX_W'(inc);
    end

    always_comb begin : c_prod
        num_next   = {{SEG_W{1'b0}}, HALF_PI_Q32} * {{HP_W{1'b0}}, r_reg};
        ps_next.q  = q_reg;
        ps_next.rz = (r_reg == '0);
        ps_next.i  = qi_reg;
        ps_next.nx = qn_reg;
    end

    // The residual angle quotient fits in HP_W bits, so the top bits of the
    // product already sit below the divisor and start as the remainder.
    always_comb begin : c_div
        logic [SEG_W-1:0] prem;
        logic [HP_W-1:0]  pacc;
        logic [SEG_W-1:0] ptr;
        logic [TEX_W-1:0] ptq;
        logic [SEG_W:0]   trial;
        logic [SEG_W:0]   ttrial;
        for (int t = 0; t < DIV_STEPS; t++) begin
            if (t == 0) begin
                prem       = num_reg[NUM_W-1:HP_W];
                pacc       = num_reg[HP_W-1:0];
                ptr        = {1'b0, ps_reg.i};
                ptq        = '0;
                ds_next[t] = ps_reg;
            end else begin
                prem       = drem_reg[t-1];
                pacc       = dacc_reg[t-1];
                ptr        = trem_reg[t-1];
                ptq        = tq_reg[t-1];
                ds_next[t] = ds_reg[t-1];
            end
            trial = {prem, pacc[HP_W-1]};
            if (trial >= {1'b0, seg}) begin
                drem_next[t] = SEG_W'(trial - {1'b0, seg});
                dacc_next[t] = {pacc[HP_W-2:0], 1'b1};
            end else begin
                drem_next[t] = trial[SEG_W-1:0];
                dacc_next[t] = {pacc[HP_W-2:0], 1'b0};
            end
            ttrial = {ptr, 1'b0};
            if (t < TEX_W) begin
                if (ttrial >= {1'b0, seg}) begin
                    trem_next[t] = SEG_W'(ttrial - {1'b0, seg});
                    tq_next[t]   = {ptq[TEX_W-2:0], 1'b1};
                end else begin
                    trem_next[t] = ttrial[SEG_W-1:0];
                    tq_next[t]   = {ptq[TEX_W-2:0], 1'b0};
                end
            end else begin
                trem_next[t] = ptr;
                tq_next[t]   = ptq;
            end
        end
    end

    always_comb begin : c_cordic
        logic signed [XY_W-1:0] px;
        logic signed [XY_W-1:0] py;
        logic signed [Z_W-1:0]  pz;
        for (int t = 0; t < CORDIC_STAGES; t++) begin
            if (t == 0) begin
                px         = GAIN_Q30;
                py         = '0;
                pz         = $signed({{(Z_W - HP_W){1'b0}}, dacc_reg[DIV_STEPS-1]});
                cs_next[t] = ds_reg[DIV_STEPS-1];
                ct_next[t] = tq_reg[DIV_STEPS-1];
            end else begin
                px         = cx_reg[t-1];
                py         = cy_reg[t-1];
                pz         = cz_reg[t-1];
                cs_next[t] = cs_reg[t-1];
                ct_next[t] = ct_reg[t-1];
            end
            if (!pz[Z_W-1]) begin
                cx_next[t] = px - (py >>> t);
                cy_next[t] = py + (px >>> t);
                cz_next[t] = pz - atan_w[t];
            end else begin
                cx_next[t] = px + (py >>> t);
                cy_next[t] = py - (px >>> t);
                cz_next[t] = pz + atan_w[t];
            end
        end
    end

    // Clamp to [0, 1], then rotate into the quadrant.
    always_comb begin : c_final
        logic signed [XY_W-1:0]   xl;
        logic signed [XY_W-1:0]   yl;
        logic signed [TRIG_W-1:0] c;
        logic signed [TRIG_W-1:0] sn;
        side_t                    sd;
        xl = cx_reg[CORDIC_STAGES-1];
        yl = cy_reg[CORDIC_STAGES-1];
        sd = cs_reg[CORDIC_STAGES-1];
        if (xl < 0) begin
            c = '0;
        end else if (xl > ONE_Q30) begin
            c = ONE_Q30;
        end else begin
            c = TRIG_W'(xl);
        end
        if (yl < 0) begin
            sn = '0;
        end else if (yl > ONE_Q30) begin
            sn = ONE_Q30;
        end else begin
            sn = TRIG_W'(yl);
        end
        if (sd.rz) begin
            c  = ONE_Q30;
            sn = '0;
        end
        case (sd.q)
            2'd0: begin
                res_next.cos_v = c;
                res_next.sin_v = sn;
            end
            2'd1: begin
                res_next.cos_v = -sn;
                res_next.sin_v = c;
            end
            2'd2: begin
                res_next.cos_v = -c;
                res_next.sin_v = -sn;
            end
            default: begin
                res_next.cos_v = sn;
                res_next.sin_v = -c;
            end
        endcase
        res_next.idx = sd.i;
        res_next.nxt = sd.nx;
        res_next.tex = ct_reg[CORDIC_STAGES-1];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int t = 0; t < IDX_W; t++) begin
                mrem_reg[t] <= mrem_next[t];
                mk_reg[t]   <= mk_next[t];
            end
            q_reg   <= q_next;
            r_reg   <= r_next;
            qi_reg  <= qi_next;
            qn_reg  <= qn_next;
            num_reg <= num_next;
            ps_reg  <= ps_next;
            for (int t = 0; t < DIV_STEPS; t++) begin
                drem_reg[t] <= drem_next[t];
                dacc_reg[t] <= dacc_next[t];
                trem_reg[t] <= trem_next[t];
                tq_reg[t]   <= tq_next[t];
                ds_reg[t]   <= ds_next[t];
            end
            for (int t = 0; t < CORDIC_STAGES; t++) begin
                cx_reg[t] <= cx_next[t];
                cy_reg[t] <= cy_next[t];
                cz_reg[t] <= cz_next[t];
                cs_reg[t] <= cs_next[t];
                ct_reg[t] <= ct_next[t];
            end
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

/* src/torus_vertex_generator.sv */
// ----------------------------------------------------------------------------
// Torus vertex generator
// Turns a (ring, tube) grid point into vertex position, unit normal, texture
// coordinates and the four quad corner indices of a parametric torus.
// ----------------------------------------------------------------------------
// The block takes one grid word per clock and returns one vertex word per
// clock once the pipeline is full. Most of the pipeline depth is the
// 33-step residual-angle divider and the CORDIC rotation, each one step
// per register stage, run for the ring and tube angles side by side. The
// whole pipeline holds while a finished vertex waits on m_tready, and
// s_tready is low during that time. The four configuration registers
// must only be written while no word is in flight.
module torus_vertex_generator import tvg_pkg::*; #(
    parameter int MAX_SEGMENTS  = MAX_SEGMENTS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    // Configuration write port.
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_addr,
    input  logic [CFG_W-1:0] cfg_wr_data,
    // Grid point input.
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // ring_index, tube_index, zero pad
    // Vertex output.
    output logic             m_tvalid,
    input  logic             m_tready,
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
    // idx_current, idx_next_tube, idx_next_ring, idx_next_both, zero pad
    output logic [OUT_W-1:0] m_tdata
);

    localparam int LANE_LAT = IDX_W + 2 + DIV_STEPS + CORDIC_STAGES + 1;
    localparam int PIPE     = LANE_LAT + 4;

    logic [RAD_W-1:0] ring_radius_reg;
    logic [RAD_W-1:0] tube_radius_reg;
    logic [SEG_W-1:0] ring_segments_reg;
    logic [SEG_W-1:0] tube_segments_reg;
    logic [SEG_W-1:0] n_eff;
    logic [SEG_W-1:0] m_eff;

    logic [PIPE-1:0] vld_reg, vld_next;
    logic            en;

    lane_out_t ring_res;
    lane_out_t tube_res;

    // Stage E1.
    logic signed [48:0]        tc2_reg, tc2_next;
    logic signed [48:0]        ts2_reg, ts2_next;
    logic signed [63:0]        ncx_reg, ncx_next;
    logic signed [63:0]        ncy_reg, ncy_next;
    logic signed [16:0]        sz_reg, sz_next;
    logic signed [TRIG_W-1:0]  c1_e1_reg, s1_e1_reg;
    logic [20:0]               im_reg, im_next;
    logic [20:0]               nim_reg, nim_next;
    logic [IDX_W-1:0]          j_e1_reg, nj_e1_reg;
    logic [TEX_W-1:0]          tu_e1_reg, tv_e1_reg;

    // Stage E2.
    logic signed [33:0]        a_reg, a_next;
    logic signed [POSZ_W-1:0]  pz_e2_reg, pz_e2_next;
    logic signed [NORM_W-1:0]  nx_e2_reg, nx_e2_next;
    logic signed [NORM_W-1:0]  ny_e2_reg, ny_e2_next;
    logic signed [NORM_W-1:0]  nz_e2_reg, nz_e2_next;
    logic [VIDX_W-1:0]         v0_e2_reg, v1_e2_reg, v2_e2_reg, v3_e2_reg;
    logic [VIDX_W-1:0]         v0_next, v1_next, v2_next, v3_next;
    logic signed [TRIG_W-1:0]  c1_e2_reg, s1_e2_reg;
    logic [TEX_W-1:0]          tu_e2_reg, tv_e2_reg;

    // Stage E3.
    logic signed [65:0]        pax_reg, pax_next;
    logic signed [65:0]        pay_reg, pay_next;
    logic signed [POSZ_W-1:0]  pz_e3_reg;
    logic signed [NORM_W-1:0]  nx_e3_reg, ny_e3_reg, nz_e3_reg;
    logic [VIDX_W-1:0]         v0_e3_reg, v1_e3_reg, v2_e3_reg, v3_e3_reg;
    logic [TEX_W-1:0]          tu_e3_reg, tv_e3_reg;

    // Output stage.
    logic signed [POSXY_W-1:0] px_reg, px_next;
    logic signed [POSXY_W-1:0] py_reg, py_next;
    logic signed [POSZ_W-1:0]  pz_reg;
    logic signed [NORM_W-1:0]  nx_reg, ny_reg, nz_reg;
    logic [VIDX_W-1:0]         v0_reg, v1_reg, v2_reg, v3_reg;
    logic [TEX_W-1:0]          tu_reg, tv_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_radius_reg   <= RING_RADIUS_RST;
            tube_radius_reg   <= TUBE_RADIUS_RST;
            ring_segments_reg <= RING_SEGS_RST;
            tube_segments_reg <= TUBE_SEGS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_RING_RADIUS:   ring_radius_reg   <= cfg_wr_data;
                CFG_TUBE_RADIUS:   tube_radius_reg   <= cfg_wr_data;
                CFG_RING_SEGMENTS: ring_segments_reg <= cfg_wr_data[SEG_W-1:0];
                CFG_TUBE_SEGMENTS: tube_segments_reg <= cfg_wr_data[SEG_W-1:0];
                default: ;
            endcase
        end
    end

    // A zero count acts as one and a count above the limit saturates.
    always_comb begin
        if (ring_segments_reg == '0) begin
            n_eff = SEG_W'(1);
        end else if (32'(ring_segments_reg) > MAX_SEGMENTS) begin
            n_eff = SEG_W'(MAX_SEGMENTS);
        end else begin
            n_eff = ring_segments_reg;
        end
        if (tube_segments_reg == '0) begin
            m_eff = SEG_W'(1);
        end else if (32'(tube_segments_reg) > MAX_SEGMENTS) begin
            m_eff = SEG_W'(MAX_SEGMENTS);
        end else begin
            m_eff = tube_segments_reg;
        end
    end

    // The pipeline advances whenever the output word is empty or taken.
    assign en       = !vld_reg[PIPE-1] || m_tready;
    assign s_tready = en;
    assign vld_next = {vld_reg[PIPE-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    tvg_lane #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_ring_lane (
        .aclk  (aclk),
        .en    (en),
        .k_in  (s_tdata[IDX_W-1:0]),
        .seg   (n_eff),
        .res   (ring_res)
    );

    tvg_lane #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_tube_lane (
        .aclk  (aclk),
        .en    (en),
        .k_in  (s_tdata[2*IDX_W-1:IDX_W]),
        .seg   (m_eff),
        .res   (tube_res)
    );

    always_comb begin : c_e1
        logic signed [RAD_W:0]  tr_s;
        logic signed [TRIG_W:0] s2r;
        tr_s     = $signed({1'b0, tube_radius_reg});
        tc2_next = tr_s * $signed(tube_res.cos_v);
        ts2_next = tr_s * $signed(tube_res.sin_v);
        ncx_next = $signed(tube_res.cos_v) * $signed(ring_res.cos_v);
        ncy_next = $signed(tube_res.cos_v) * $signed(ring_res.sin_v);
        s2r      = $signed({tube_res.sin_v[TRIG_W-1], tube_res.sin_v}) + 33'sd32768;
        sz_next  = 17'(s2r >>> 16);
        im_next  = {11'b0, ring_res.idx} * {10'b0, m_eff};
        nim_next = {11'b0, ring_res.nxt} * {10'b0, m_eff};
    end

    always_comb begin : c_e2
        logic signed [49:0] asum;
        logic signed [49:0] zsum;
        asum = $signed({4'b0, ring_radius_reg, 30'b0}) + 50'(tc2_reg) + 50'sd32768;
        a_next = 34'(asum >>> 16);
        zsum = 50'(ts2_reg) + (50'sd1 <<< 29);
        pz_e2_next = POSZ_W'(zsum >>> 30);
        if (tube_radius_reg == '0) begin
            nx_e2_next = '0;
            ny_e2_next = '0;
            nz_e2_next = '0;
        end else if (ring_radius_reg == '0) begin
            // No radial direction: the normal points straight up or down, or is zero when the tube sine is zero.
            nx_e2_next = '0;
            ny_e2_next = '0;
            if (sz_reg > 0) begin
                nz_e2_next = 16'sd16384;
            end else if (sz_reg < 0) begin
                nz_e2_next = -16'sd16384;
            end else begin
                nz_e2_next = '0;
            end
        end else begin
            nx_e2_next = NORM_W'((ncx_reg + (64'sd1 <<< 45)) >>> 46);
            ny_e2_next = NORM_W'((ncy_reg + (64'sd1 <<< 45)) >>> 46);
            nz_e2_next = NORM_W'(sz_reg);
        end
        v0_next = VIDX_W'(im_reg + 21'(j_e1_reg));
        v1_next = VIDX_W'(im_reg + 21'(nj_e1_reg));
        v2_next = VIDX_W'(nim_reg + 21'(j_e1_reg));
        v3_next = VIDX_W'(nim_reg + 21'(nj_e1_reg));
    end

    always_comb begin : c_e3
        pax_next = a_reg * c1_e2_reg;
        pay_next = a_reg * s1_e2_reg;
    end

    always_comb begin : c_e4
        if (ring_radius_reg == '0) begin
            px_next = '0;
            py_next = '0;
        end else begin
            px_next = POSXY_W'((pax_reg + (66'sd1 <<< 43)) >>> 44);
            py_next = POSXY_W'((pay_reg + (66'sd1 <<< 43)) >>> 44);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tc2_reg   <= tc2_next;
            ts2_reg   <= ts2_next;
            ncx_reg   <= ncx_next;
            ncy_reg   <= ncy_next;
            sz_reg    <= sz_next;
            c1_e1_reg <= ring_res.cos_v;
            s1_e1_reg <= ring_res.sin_v;
            im_reg    <= im_next;
            nim_reg   <= nim_next;
            j_e1_reg  <= tube_res.idx;
            nj_e1_reg <= tube_res.nxt;
            tu_e1_reg <= ring_res.tex;
            tv_e1_reg <= tube_res.tex;

            a_reg     <= a_next;
            pz_e2_reg <= pz_e2_next;
            nx_e2_reg <= nx_e2_next;
            ny_e2_reg <= ny_e2_next;
            nz_e2_reg <= nz_e2_next;
            v0_e2_reg <= v0_next;
            v1_e2_reg <= v1_next;
            v2_e2_reg <= v2_next;
            v3_e2_reg <= v3_next;
            c1_e2_reg <= c1_e1_reg;
            s1_e2_reg <= s1_e1_reg;
            tu_e2_reg <= tu_e1_reg;
            tv_e2_reg <= tv_e1_reg;

            pax_reg   <= pax_next;
            pay_reg   <= pay_next;
            pz_e3_reg <= pz_e2_reg;
            nx_e3_reg <= nx_e2_reg;
            ny_e3_reg <= ny_e2_reg;
            nz_e3_reg <= nz_e2_reg;
            v0_e3_reg <= v0_e2_reg;
            v1_e3_reg <= v1_e2_reg;
            v2_e3_reg <= v2_e2_reg;
            v3_e3_reg <= v3_e2_reg;
            tu_e3_reg <= tu_e2_reg;
            tv_e3_reg <= tv_e2_reg;

            px_reg    <= px_next;
            py_reg    <= py_next;
            pz_reg    <= pz_e3_reg;
            nx_reg    <= nx_e3_reg;
            ny_reg    <= ny_e3_reg;
            nz_reg    <= nz_e3_reg;
            v0_reg    <= v0_e3_reg;
            v1_reg    <= v1_e3_reg;
            v2_reg    <= v2_e3_reg;
            v3_reg    <= v3_e3_reg;
            tu_reg    <= tu_e3_reg;
            tv_reg    <= tv_e3_reg;
        end
    end

    assign m_tvalid = vld_reg[PIPE-1];
    assign m_tdata  = {3'b000, v3_reg, v2_reg, v1_reg, v0_reg, tv_reg, tu_reg,
                       nz_reg, ny_reg, nx_reg, pz_reg, py_reg, px_reg};

endmodule
